>>> hw/rtl/mtp_pkg.sv
package mtp_pkg;

  localparam int POS_W   = 16;
  localparam int FRAC_W  = 16;
  localparam int SPD_W   = 24;
  localparam int DUR_W   = 16;
  localparam int ACT_W   = 32;
  localparam int LEN_W   = 33;
  localparam int D2_W    = 33;
  localparam int CARRY_W = 18;
  localparam int NUM_W   = 66;
  localparam int QUO_W   = 64;
  localparam int CNT_W   = 7;

  localparam logic [SPD_W-1:0] SPEED_RESET = 24'd655360;

  localparam logic [1:0] REG_DEST_X   = 2'd0;
  localparam logic [1:0] REG_DEST_Y   = 2'd1;
  localparam logic [1:0] REG_SPEED    = 2'd2;
  localparam logic [1:0] REG_DURATION = 2'd3;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } alu_op_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic [CNT_W-1:0] cnt;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ROOT,
    ST_DUR,
    ST_MUL_X,
    ST_DIV_X,
    ST_MUL_Y,
    ST_DIV_Y,
    ST_MOVE,
    ST_RSQ_X,
    ST_RSQ_Y,
    ST_RROOT,
    ST_TDIV,
    ST_DONE
  } state_t;

endpackage

>>> hw/rtl/mtp_alu.sv
module mtp_alu
  import mtp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  alu_req_t         req,
  input  logic [NUM_W-1:0] num,
  input  logic [LEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] res
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  alu_op_t          op_r;
  logic [NUM_W-1:0] sh_r;
  logic [LEN_W-1:0] den_r;
  logic [35:0]      rem_r;
  logic [QUO_W-1:0] q_r;

  logic [35:0]      rem_sh;
  logic [35:0]      trial;
  logic             ge;
  logic [35:0]      rem_nxt;
  logic [NUM_W-1:0] sh_nxt;

  // one restoring step: a root bit or a quotient bit
  always_comb begin
    if (op_r == OP_SQRT) begin
      rem_sh = {rem_r[33:0], sh_r[NUM_W-1 -: 2]};
      trial  = {1'b0, q_r[32:0], 2'b01};
      sh_nxt = {sh_r[NUM_W-3:0], 2'b00};
    end else begin
      rem_sh = {rem_r[34:0], sh_r[NUM_W-1]};
      trial  = {3'b000, den_r};
      sh_nxt = {sh_r[NUM_W-2:0], 1'b0};
    end
    ge      = (rem_sh >= trial);
    rem_nxt = ge ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.cnt;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r  <= req.op;
      sh_r  <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      sh_r  <= sh_nxt;
      rem_r <= rem_nxt;
      q_r   <= {q_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign res  = q_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r) else $error("alu started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("alu done without work");
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("alu count ran out");

endmodule

>>> hw/rtl/move_toward_point_stepper_unit.sv
// move-toward-point stepper
// in_*: one word per tick with the object's current position,
//   tdata = cur_x, cur_y (16 bit signed each)
// out_*: one word per input word with the new position,
//   tdata = next_x, next_y, time_left (Q16.16 ticks, saturating),
//   tlast = finished (destination reached, time_left is zero)
// cfg_*: register writes while idle: 0 dest_x, 1 dest_y, 2 speed (Q8.16,
//   loads the active speed), 3 duration (nonzero arms duration mode)
// one shared bit-serial unit does both square roots (33 steps) and all
//   divisions (33 to 64 steps); an item that finishes needs one root, one
//   that moves two roots and up to three divisions, plus one division on
//   the first tick in duration mode; in_tready is high only between items
// reset: destination 0, speed 10.0, constant speed mode, carries zero
// a stalled receiver holds the result in the output register; the next
//   item is still accepted and waits at its end until that register frees
module move_toward_point_stepper_unit
  import mtp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // cur_x, cur_y
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // next_x, next_y, time_left
  output logic                 out_tlast,  // finished
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [SPD_W-1:0]     cfg_wdata
);

  state_t state_r, state_nxt;

  logic signed [POS_W-1:0]   dest_x_r, dest_y_r;
  logic [DUR_W-1:0]          duration_r;
  logic [ACT_W-1:0]          act_r;
  logic                      pend_r;
  logic signed [CARRY_W-1:0] carry_x_r, carry_y_r;

  logic signed [POS_W-1:0]   cx_r, cy_r;
  logic [POS_W-1:0]          ax_r, ay_r;
  logic                      negx_r, negy_r;
  logic [D2_W-1:0]           d2_r;
  logic [LEN_W-1:0]          len_r;
  logic [47:0]               prod_r;
  logic [ACT_W-1:0]          sx_r, sy_r;
  logic [POS_W-1:0]          nx_r, ny_r;
  logic                      fin_r;
  logic [31:0]               t_r;
  logic                      issued_r;

  logic                      out_valid_r;
  logic [63:0]               out_data_r;
  logic                      out_last_r;

  logic [ACT_W-1:0]          mul_a;
  logic [POS_W-1:0]          mul_b;
  logic [47:0]               prod;
  logic signed [POS_W:0]     dx_in, dy_in;
  logic [33:0]               adv_x, adv_y;
  logic [POS_W-1:0]          nx_c, ny_c;
  logic signed [POS_W:0]     rx_c, ry_c;
  logic                      op_state;
  alu_req_t                  alu_req;
  logic [NUM_W-1:0]          alu_num;
  logic [LEN_W-1:0]          alu_den;
  logic                      alu_done;
  logic [QUO_W-1:0]          alu_res;
  logic                      out_free;

  // add the step to the carry, split off the whole move toward zero
  function automatic logic [33:0] adv_f(input logic signed [CARRY_W-1:0] c,
                                        input logic neg, input logic [ACT_W-1:0] m);
    logic signed [34:0] acc;
    logic [34:0]        macc;
    logic [15:0]        wm;
    logic [15:0]        rm;
    logic [15:0]        w;
    logic [17:0]        cn;
    acc  = 35'(c) + (neg ? -$signed({3'b000, m}) : $signed({3'b000, m}));
    macc = acc[34] ? 35'(-acc) : 35'(acc);
    wm   = macc[31:16];
    rm   = macc[15:0];
    w    = acc[34] ? 16'(16'd0 - wm) : wm;
    cn   = acc[34] ? 18'(18'd0 - {2'b00, rm}) : {2'b00, rm};
    return {w, cn};
  endfunction

  assign dx_in = {dest_x_r[POS_W-1], dest_x_r} - {in_tdata[15], in_tdata[15:0]};
  assign dy_in = {dest_y_r[POS_W-1], dest_y_r} - {in_tdata[31], in_tdata[31:16]};

  assign prod = 48'(mul_a) * 48'(mul_b);

  assign adv_x = adv_f(carry_x_r, negx_r, sx_r);
  assign adv_y = adv_f(carry_y_r, negy_r, sy_r);
  assign nx_c  = cx_r + adv_x[33:18];
  assign ny_c  = cy_r + adv_y[33:18];
  assign rx_c  = {dest_x_r[POS_W-1], dest_x_r} - {nx_c[POS_W-1], nx_c};
  assign ry_c  = {dest_y_r[POS_W-1], dest_y_r} - {ny_c[POS_W-1], ny_c};

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    mul_a = {16'd0, ax_r};
    mul_b = ax_r;
    case (state_r)
      ST_SQ_Y, ST_RSQ_Y: begin
        mul_a = {16'd0, ay_r};
        mul_b = ay_r;
      end
      ST_MUL_X: begin
        mul_a = act_r;
        mul_b = ax_r;
      end
      ST_MUL_Y: begin
        mul_a = act_r;
        mul_b = ay_r;
      end
      default: begin
        mul_a = {16'd0, ax_r};
        mul_b = ax_r;
      end
    endcase
  end

  always_comb begin
    op_state = 1'b0;
    alu_req  = '{start: 1'b0, op: OP_DIV, cnt: CNT_W'(64)};
    alu_num  = {prod_r, 18'd0};
    alu_den  = len_r;
    case (state_r)
      ST_ROOT, ST_RROOT: begin
        op_state    = 1'b1;
        alu_req.op  = OP_SQRT;
        alu_req.cnt = CNT_W'(33);
        alu_num     = {1'b0, d2_r, 32'd0};
      end
      ST_DUR: begin
        op_state    = 1'b1;
        alu_req.cnt = CNT_W'(33);
        alu_num     = {len_r, 33'd0};
        alu_den     = {17'd0, duration_r};
      end
      ST_DIV_X, ST_DIV_Y: begin
        op_state = 1'b1;
      end
      ST_TDIV: begin
        op_state    = 1'b1;
        alu_req.cnt = CNT_W'(49);
        alu_num     = {len_r, 33'd0};
        alu_den     = {1'b0, act_r};
      end
      default: begin
        op_state = 1'b0;
      end
    endcase
    alu_req.start = op_state && !issued_r;
  end

  mtp_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .num   (alu_num),
    .den   (alu_den),
    .done  (alu_done),
    .res   (alu_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_SQ_X;
      ST_SQ_X:  state_nxt = ST_SQ_Y;
      ST_SQ_Y:  state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (alu_done) state_nxt = (pend_r && duration_r != '0) ? ST_DUR : ST_MUL_X;
      end
      ST_DUR:   if (alu_done) state_nxt = ST_MUL_X;
      ST_MUL_X: state_nxt = ({1'b0, len_r} <= {2'b00, act_r}) ? ST_DONE : ST_DIV_X;
      ST_DIV_X: if (alu_done) state_nxt = ST_MUL_Y;
      ST_MUL_Y: state_nxt = ST_DIV_Y;
      ST_DIV_Y: if (alu_done) state_nxt = ST_MOVE;
      ST_MOVE:  state_nxt = ST_RSQ_X;
      ST_RSQ_X: state_nxt = ST_RSQ_Y;
      ST_RSQ_Y: state_nxt = ST_RROOT;
      ST_RROOT: begin
        if (alu_done) state_nxt = (act_r == '0) ? ST_DONE : ST_TDIV;
      end
      ST_TDIV:  if (alu_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      dest_x_r    <= '0;
      dest_y_r    <= '0;
      duration_r  <= '0;
      act_r       <= {8'd0, SPEED_RESET};
      pend_r      <= 1'b0;
      carry_x_r   <= '0;
      carry_y_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (alu_req.start) issued_r <= 1'b1;
      else if (alu_done) issued_r <= 1'b0;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_ROOT: if (alu_done) pend_r <= 1'b0;
        ST_DUR: begin
          if (alu_done) act_r <= alu_res[32] ? 32'hFFFF_FFFF : alu_res[31:0];
        end
        ST_MOVE: begin
          carry_x_r <= adv_x[17:0];
          carry_y_r <= adv_y[17:0];
        end
        default: begin
        end
      endcase
      if (cfg_we) begin
        case (cfg_addr)
          REG_DEST_X: dest_x_r <= cfg_wdata[POS_W-1:0];
          REG_DEST_Y: dest_y_r <= cfg_wdata[POS_W-1:0];
          REG_SPEED: begin
            act_r <= {8'd0, cfg_wdata};
          end
          REG_DURATION: begin
            duration_r <= cfg_wdata[DUR_W-1:0];
            pend_r     <= (cfg_wdata[DUR_W-1:0] != '0);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cx_r   <= in_tdata[15:0];
        cy_r   <= in_tdata[31:16];
        negx_r <= dx_in[POS_W];
        negy_r <= dy_in[POS_W];
        ax_r   <= dx_in[POS_W] ? POS_W'(-dx_in) : POS_W'(dx_in);
        ay_r   <= dy_in[POS_W] ? POS_W'(-dy_in) : POS_W'(dy_in);
      end
      ST_SQ_X, ST_RSQ_X: d2_r <= D2_W'(prod);
      ST_SQ_Y, ST_RSQ_Y: d2_r <= d2_r + D2_W'(prod);
      ST_ROOT, ST_RROOT: if (alu_done) len_r <= alu_res[LEN_W-1:0];
      ST_MUL_X: begin
        prod_r <= prod;
        nx_r   <= dest_x_r;
        ny_r   <= dest_y_r;
        fin_r  <= 1'b1;
        t_r    <= '0;
      end
      ST_DIV_X: if (alu_done) sx_r <= alu_res[ACT_W-1:0];
      ST_MUL_Y: prod_r <= prod;
      ST_DIV_Y: if (alu_done) sy_r <= alu_res[ACT_W-1:0];
      ST_MOVE: begin
        nx_r  <= nx_c;
        ny_r  <= ny_c;
        fin_r <= 1'b0;
        t_r   <= 32'hFFFF_FFFF;
        ax_r  <= rx_c[POS_W] ? POS_W'(-rx_c) : POS_W'(rx_c);
        ay_r  <= ry_c[POS_W] ? POS_W'(-ry_c) : POS_W'(ry_c);
      end
      ST_TDIV: begin
        if (alu_done) t_r <= (alu_res[48:32] != '0) ? 32'hFFFF_FFFF : alu_res[31:0];
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r <= {t_r, ny_r, nx_r};
          out_last_r <= fin_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  a_fin_no_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[63:32] == '0)
    else $error("finished word with time left");
  a_pend_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL_X |-> !pend_r) else $error("duration still pending");
  a_done_in_op: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> op_state && issued_r) else $error("alu result unclaimed");
  a_idle_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_free |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not loaded");

endmodule
